// ===== rtl/wect_pkg.sv =====
`timescale 1ns / 1ps
package wect_pkg;

	localparam int MODE_W   = 2;
	localparam int SYM_W    = 8;
	localparam int SWITCH_W = 16;
	localparam int COST_W   = 23;
	localparam int WCOUNT_W = 17;
	localparam int FLAG_W   = 2;

	localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

	localparam logic [FLAG_W-1:0] FLAG_OK        = 2'd0;
	localparam logic [FLAG_W-1:0] FLAG_EMPTY_BIN = 2'd1;
	localparam logic [FLAG_W-1:0] FLAG_SATURATED = 2'd2;

	localparam logic [SWITCH_W-1:0] BASE_SWITCH_BITS = 16'd640;
	localparam logic [SWITCH_W-1:0] HEADER_BITS      = 16'd12;
	localparam logic [SWITCH_W-1:0] SWITCH_RESET     = BASE_SWITCH_BITS + HEADER_BITS;

	localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

	typedef struct packed {
		logic             commit;
		logic             clr;
		logic             wr;
		logic [SYM_W-1:0] sym;
	} hist_cmd_t;

endpackage

// ===== rtl/wect_in_if.sv =====
`timescale 1ns / 1ps
interface wect_in_if;
	logic                        valid;
	logic                        ready;
	logic [wect_pkg::MODE_W-1:0] mode;
	logic [wect_pkg::SYM_W-1:0]  symbol;

	modport source (output valid, output mode, output symbol, input ready);
	modport sink (input valid, input mode, input symbol, output ready);
endinterface

// ===== rtl/wect_out_if.sv =====
`timescale 1ns / 1ps
interface wect_out_if;
	logic                          valid;
	logic                          ready;
	logic [wect_pkg::COST_W-1:0]   block_cost;
	logic [wect_pkg::WCOUNT_W-1:0] window_count;
	logic [wect_pkg::FLAG_W-1:0]   error_flag;

	modport source (output valid, output block_cost, output window_count, output error_flag,
		input ready);
	modport sink (input valid, input block_cost, input window_count, input error_flag,
		output ready);
endinterface

// ===== rtl/wect_hist_store.sv =====
`timescale 1ns / 1ps
module wect_hist_store #(
	parameter int ALPHABET_SIZE = 256,
	parameter int COUNT_WIDTH   = 17
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [wect_pkg::SYM_W-1:0]  rd_sym,
	input  wect_pkg::hist_cmd_t         cmd,
	input  logic [COUNT_WIDTH-1:0]      wr_count,
	output logic [COUNT_WIDTH-1:0]      count
);

	localparam int IDX_W = $clog2(ALPHABET_SIZE);

	logic [COUNT_WIDTH-1:0]   mem [ALPHABET_SIZE];
	logic [ALPHABET_SIZE-1:0] valid_q;
	logic [COUNT_WIDTH-1:0]   rd_data_s1;
	logic                     rd_valid_s1;
	logic                     fwd_s1;
	logic [COUNT_WIDTH-1:0]   fwd_data_s1;
	logic [IDX_W-1:0]         rd_idx;
	logic [IDX_W-1:0]         wr_idx;

	assign rd_idx = rd_sym[IDX_W-1:0];
	assign wr_idx = cmd.sym[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.commit && cmd.wr) begin
			mem[wr_idx] <= wr_count;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_idx];
		end
	end

	// bins not written since reset or the last clear read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
			fwd_s1      <= 1'b0;
			fwd_data_s1 <= '0;
		end else begin
			if (rd_en) begin
				rd_valid_s1 <= valid_q[rd_idx];
				fwd_s1      <= cmd.commit && (cmd.clr || (cmd.wr && wr_idx == rd_idx));
				fwd_data_s1 <= cmd.clr ? '0 : wr_count;
			end
			if (cmd.commit && cmd.clr) begin
				valid_q <= '0;
			end else if (cmd.commit && cmd.wr) begin
				valid_q[wr_idx] <= 1'b1;
			end
		end
	end

	always_comb begin
		if (fwd_s1) begin
			count = fwd_data_s1;
		end else if (rd_valid_s1) begin
			count = rd_data_s1;
		end else begin
			count = '0;
		end
	end

endmodule

// ===== rtl/wect_update.sv =====
`timescale 1ns / 1ps
module wect_update #(
	parameter int ALPHABET_SIZE = 256,
	parameter int COUNT_WIDTH   = 17,
	parameter int SUM_W         = 22
) (
	input  logic [wect_pkg::MODE_W-1:0]   mode,
	input  logic [wect_pkg::SYM_W-1:0]    symbol,
	input  logic [COUNT_WIDTH-1:0]        bin_count,
	input  logic [COUNT_WIDTH-1:0]        total,
	input  logic [SUM_W-1:0]              total_weight,
	input  logic [SUM_W-1:0]              weighted_sum,
	input  logic [wect_pkg::SWITCH_W-1:0] switch_cost,
	output logic                          wr,
	output logic                          clr,
	output logic [COUNT_WIDTH-1:0]        bin_count_nxt,
	output logic [COUNT_WIDTH-1:0]        total_nxt,
	output logic [SUM_W-1:0]              total_weight_nxt,
	output logic [SUM_W-1:0]              weighted_sum_nxt,
	output logic [wect_pkg::COST_W-1:0]   block_cost,
	output logic [wect_pkg::WCOUNT_W-1:0] window_count,
	output logic [wect_pkg::FLAG_W-1:0]   error_flag
);

	localparam int LOG_W   = $clog2(COUNT_WIDTH);
	localparam int ADD_W   = (SUM_W > wect_pkg::SWITCH_W ? SUM_W : wect_pkg::SWITCH_W) + 1;
	localparam int CMP_W   = ADD_W > wect_pkg::COST_W ? ADD_W : wect_pkg::COST_W;
	localparam int OUTC_W  = COUNT_WIDTH > wect_pkg::WCOUNT_W ? COUNT_WIDTH : wect_pkg::WCOUNT_W;
	localparam logic [wect_pkg::SYM_W:0] ALPHA_LIM = (wect_pkg::SYM_W + 1)'(ALPHABET_SIZE);

	// x*floor(log2 x) - (x-1)*floor(log2 (x-1)) for x >= 1
	function automatic logic [SUM_W-1:0] step_weight(input logic [COUNT_WIDTH-1:0] x);
		logic [LOG_W-1:0]       lg;
		logic [COUNT_WIDTH-1:0] xm1;
		logic [SUM_W-1:0]       d;
		lg = '0;
		for (int i = 1; i < COUNT_WIDTH; i++) begin
			if (x[i]) begin
				lg = LOG_W'(i);
			end
		end
		xm1 = x - COUNT_WIDTH'(1);
		d = SUM_W'(lg);
		if ((x & xm1) == '0) begin
			d = d + SUM_W'(xm1);
		end
		return d;
	endfunction

	logic                   in_range;
	logic                   do_add;
	logic                   do_rem;
	logic [COUNT_WIDTH-1:0] bin_up;
	logic [COUNT_WIDTH-1:0] total_up;
	logic [SUM_W-1:0]       bin_step;
	logic [SUM_W-1:0]       total_step;
	logic [SUM_W-1:0]       diff;
	logic [CMP_W-1:0]       cost_w;
	logic [OUTC_W-1:0]      total_ext;

	assign in_range = {1'b0, symbol} < ALPHA_LIM;
	assign bin_up   = bin_count + COUNT_WIDTH'(1);
	assign total_up = total + COUNT_WIDTH'(1);

	always_comb begin
		do_add     = 1'b0;
		do_rem     = 1'b0;
		clr        = 1'b0;
		error_flag = wect_pkg::FLAG_OK;
		case (mode)
			wect_pkg::MODE_ADD: begin
				if (in_range) begin
					if ((&total) || (&bin_count)) begin
						error_flag = wect_pkg::FLAG_SATURATED;
					end else begin
						do_add = 1'b1;
					end
				end
			end
			wect_pkg::MODE_REMOVE: begin
				if (in_range) begin
					if (bin_count == '0 || total == '0) begin
						error_flag = wect_pkg::FLAG_EMPTY_BIN;
					end else begin
						do_rem = 1'b1;
					end
				end
			end
			wect_pkg::MODE_CLEAR: begin
				clr = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign wr            = do_add || do_rem;
	assign bin_count_nxt = do_add ? bin_up : bin_count - COUNT_WIDTH'(1);
	assign bin_step      = step_weight(do_add ? bin_up : bin_count);
	assign total_step    = step_weight(do_add ? total_up : total);

	always_comb begin
		if (clr) begin
			total_nxt        = '0;
			total_weight_nxt = '0;
			weighted_sum_nxt = '0;
		end else if (do_add) begin
			total_nxt        = total_up;
			total_weight_nxt = total_weight + total_step;
			weighted_sum_nxt = weighted_sum + bin_step;
		end else if (do_rem) begin
			total_nxt        = total - COUNT_WIDTH'(1);
			total_weight_nxt = total_weight - total_step;
			weighted_sum_nxt = weighted_sum - bin_step;
		end else begin
			total_nxt        = total;
			total_weight_nxt = total_weight;
			weighted_sum_nxt = weighted_sum;
		end
	end

	assign diff   = (total_weight_nxt >= weighted_sum_nxt) ?
		total_weight_nxt - weighted_sum_nxt : '0;
	assign cost_w = CMP_W'(switch_cost) + CMP_W'(diff);
	assign block_cost = (cost_w > CMP_W'(wect_pkg::COST_MAX)) ?
		wect_pkg::COST_MAX : cost_w[wect_pkg::COST_W-1:0];

	assign total_ext    = OUTC_W'(total_nxt);
	assign window_count = total_ext[wect_pkg::WCOUNT_W-1:0];

endmodule

// ===== rtl/window_entropy_cost_tracker.sv =====
`timescale 1ns / 1ps
// Windowed entropy cost tracker.
// item channel: one transaction per symbol event (mode add, remove or clear, and the
// symbol). result channel: one transaction per item with the estimated cost in bits
// of coding the window as one block, the symbol count of the window and an error flag.
// switch_cost is written through cfg_wr_en / cfg_wr_data; the user must write it only
// while no item is in flight, as the block does not enforce this. The accepting edge
// reads the bin from the histogram memory into the read stage; the edge on which that
// stage advances loads the updated counts and sums into the result register.
// Throughput: one item per cycle while result.ready is high; the bin read-modify-write
// forwards the count written by the item ahead, so back-to-back items on one bin need
// no bubble. Stall: while the receiver holds ready low the result register holds, one
// more item waits in the read stage, and item.ready then drops until the result is
// taken. Reset: the histogram, the weighted sum and the window count read as zero at
// once (per-bin valid bits), switch_cost returns to 652; items are taken as soon as
// reset is released. A clear item empties the window at once the same way.
module window_entropy_cost_tracker #(
	parameter int ALPHABET_SIZE = 256,
	parameter int COUNT_WIDTH   = 17
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [wect_pkg::SWITCH_W-1:0] cfg_wr_data,
	wect_in_if.sink                       item,
	wect_out_if.source                    result
);

	localparam int SUM_W = COUNT_WIDTH + $clog2(COUNT_WIDTH);

	logic                          valid_s1;
	logic [wect_pkg::MODE_W-1:0]   mode_s1;
	logic [wect_pkg::SYM_W-1:0]    symbol_s1;
	logic                          advance;
	logic                          accept;

	logic [wect_pkg::SWITCH_W-1:0] switch_cost_q;
	logic [COUNT_WIDTH-1:0]        total_q;
	logic [SUM_W-1:0]              total_weight_q;
	logic [SUM_W-1:0]              weighted_sum_q;

	logic                          out_valid_q;
	logic [wect_pkg::COST_W-1:0]   block_cost_q;
	logic [wect_pkg::WCOUNT_W-1:0] window_count_q;
	logic [wect_pkg::FLAG_W-1:0]   error_flag_q;

	logic [COUNT_WIDTH-1:0]        bin_count;
	logic                          wr;
	logic                          clr;
	logic [COUNT_WIDTH-1:0]        bin_count_nxt;
	logic [COUNT_WIDTH-1:0]        total_nxt;
	logic [SUM_W-1:0]              total_weight_nxt;
	logic [SUM_W-1:0]              weighted_sum_nxt;
	logic [wect_pkg::COST_W-1:0]   block_cost;
	logic [wect_pkg::WCOUNT_W-1:0] window_count;
	logic [wect_pkg::FLAG_W-1:0]   error_flag;
	wect_pkg::hist_cmd_t           cmd;

	assign advance    = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign accept     = item.valid && item.ready;

	assign cmd.commit = advance;
	assign cmd.clr    = clr;
	assign cmd.wr     = wr;
	assign cmd.sym    = symbol_s1;

	wect_hist_store #(
		.ALPHABET_SIZE (ALPHABET_SIZE),
		.COUNT_WIDTH   (COUNT_WIDTH)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_sym   (item.symbol),
		.cmd      (cmd),
		.wr_count (bin_count_nxt),
		.count    (bin_count)
	);

	wect_update #(
		.ALPHABET_SIZE (ALPHABET_SIZE),
		.COUNT_WIDTH   (COUNT_WIDTH),
		.SUM_W         (SUM_W)
	) u_update (
		.mode             (mode_s1),
		.symbol           (symbol_s1),
		.bin_count        (bin_count),
		.total            (total_q),
		.total_weight     (total_weight_q),
		.weighted_sum     (weighted_sum_q),
		.switch_cost      (switch_cost_q),
		.wr               (wr),
		.clr              (clr),
		.bin_count_nxt    (bin_count_nxt),
		.total_nxt        (total_nxt),
		.total_weight_nxt (total_weight_nxt),
		.weighted_sum_nxt (weighted_sum_nxt),
		.block_cost       (block_cost),
		.window_count     (window_count),
		.error_flag       (error_flag)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1   <= item.mode;
			symbol_s1 <= item.symbol;
		end
		if (advance) begin
			block_cost_q   <= block_cost;
			window_count_q <= window_count;
			error_flag_q   <= error_flag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			out_valid_q    <= 1'b0;
			switch_cost_q  <= wect_pkg::SWITCH_RESET;
			total_q        <= '0;
			total_weight_q <= '0;
			weighted_sum_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				switch_cost_q <= cfg_wr_data;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q    <= 1'b1;
				total_q        <= total_nxt;
				total_weight_q <= total_weight_nxt;
				weighted_sum_q <= weighted_sum_nxt;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid        = out_valid_q;
	assign result.block_cost   = block_cost_q;
	assign result.window_count = window_count_q;
	assign result.error_flag   = error_flag_q;

endmodule

// ===== verif/window_entropy_cost_tracker_tb.sv =====
`timescale 1ns / 1ps
module window_entropy_cost_tracker_tb;

	localparam logic [wect_pkg::MODE_W-1:0]   MODE_UNUSED = 2'd3;
	localparam logic [wect_pkg::WCOUNT_W-1:0] FULL_WINDOW = {wect_pkg::WCOUNT_W{1'b1}};
	localparam int                            STALL_LIMIT = 4000;
	localparam int                            HOLD_CYCLES = 80;
	localparam int                            ITEMS_PHASE = 110;

	typedef struct packed {
		logic [wect_pkg::COST_W-1:0]   block_cost;
		logic [wect_pkg::WCOUNT_W-1:0] window_count;
		logic [wect_pkg::FLAG_W-1:0]   error_flag;
	} window_result_t;

	class cost_scoreboard;
		logic [wect_pkg::WCOUNT_W-1:0] bin_count [256];
		longint unsigned               weighted_sum;
		logic [wect_pkg::WCOUNT_W-1:0] window_total;
		logic [wect_pkg::SWITCH_W-1:0] switch_cost;
		window_result_t                expected_q[$];
		int unsigned                   failures;

		function new();
			empty_window();
			switch_cost = wect_pkg::SWITCH_RESET;
			failures = 0;
		endfunction

		function void empty_window();
			foreach (bin_count[i]) bin_count[i] = '0;
			weighted_sum = 0;
			window_total = '0;
		endfunction

		function longint unsigned weigh(longint unsigned f);
			longint unsigned v;
			longint unsigned lg;
			v = f;
			lg = 0;
			while (v > 1) begin
				v = v >> 1;
				lg++;
			end
			return f * lg;
		endfunction

		function void set_switch_cost(logic [wect_pkg::SWITCH_W-1:0] v);
			switch_cost = v;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_item(logic [wect_pkg::MODE_W-1:0] m, logic [wect_pkg::SYM_W-1:0] s);
			window_result_t  r;
			longint unsigned f;
			longint unsigned cost;
			r.error_flag = wect_pkg::FLAG_OK;
			f = bin_count[s];
			case (m)
				wect_pkg::MODE_CLEAR: empty_window();
				wect_pkg::MODE_ADD: begin
					if (window_total == FULL_WINDOW || f >= FULL_WINDOW) begin
						r.error_flag = wect_pkg::FLAG_SATURATED;
					end else begin
						weighted_sum = weighted_sum - weigh(f) + weigh(f + 1);
						bin_count[s] = wect_pkg::WCOUNT_W'(f + 1);
						window_total = window_total + 1'b1;
					end
				end
				wect_pkg::MODE_REMOVE: begin
					if (f == 0 || window_total == 0) begin
						r.error_flag = wect_pkg::FLAG_EMPTY_BIN;
					end else begin
						weighted_sum = weighted_sum - weigh(f) + weigh(f - 1);
						bin_count[s] = wect_pkg::WCOUNT_W'(f - 1);
						window_total = window_total - 1'b1;
					end
				end
				default: ;
			endcase
			cost = longint'(switch_cost) + weigh(window_total);
			cost = (cost >= weighted_sum) ? cost - weighted_sum : 0;
			if (cost > wect_pkg::COST_MAX) cost = wect_pkg::COST_MAX;
			r.block_cost = cost[wect_pkg::COST_W-1:0];
			r.window_count = window_total;
			expected_q.push_back(r);
		endfunction

		function void check_result(logic [wect_pkg::COST_W-1:0] cost,
				logic [wect_pkg::WCOUNT_W-1:0] cnt, logic [wect_pkg::FLAG_W-1:0] flag);
			window_result_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result cost=%0d count=%0d flag=%0d",
					$time, cost, cnt, flag);
				failures++;
				return;
			end
			e = expected_q.pop_front();
			if (cost !== e.block_cost) begin
				$display("%0t: block_cost expected %0d actual %0d", $time, e.block_cost, cost);
				failures++;
			end
			if (cnt !== e.window_count) begin
				$display("%0t: window_count expected %0d actual %0d", $time,
					e.window_count, cnt);
				failures++;
			end
			if (flag !== e.error_flag) begin
				$display("%0t: error_flag expected %0d actual %0d", $time, e.error_flag, flag);
				failures++;
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_wr_en;
	logic [wect_pkg::SWITCH_W-1:0] cfg_wr_data;

	wect_in_if  in_ch ();
	wect_out_if out_ch ();

	window_entropy_cost_tracker u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.item        (in_ch),
		.result      (out_ch)
	);

	cost_scoreboard                sb = new();
	bit                            tx_eager;
	bit                            rx_eager;
	bit                            hold_request;
	int                            hold_left;
	int                            idle_cycles;
	logic [wect_pkg::SYM_W-1:0]    hot_syms [4];

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready)
				sb.check_result(out_ch.block_cost, out_ch.window_count, out_ch.error_flag);
			if (in_ch.valid && in_ch.ready)
				sb.note_item(in_ch.mode, in_ch.symbol);
			if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// receiver: random ready, with a long hold on request
	initial begin
		int r;
		out_ch.ready = 1'b0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_ch.ready = 1'b0;
				hold_left--;
			end else if (rx_eager) begin
				out_ch.ready = 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					out_ch.ready = 1'b1;
				end else begin
					out_ch.ready = 1'b0;
					hold_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 30);
				end
			end
		end
	end

	function automatic int tx_gap();
		int r;
		if (tx_eager) return 0;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 2);
		if (r < 95) return $urandom_range(3, 6);
		return $urandom_range(10, 30);
	endfunction

	// called and returns at a falling edge
	task automatic send_item(input logic [wect_pkg::MODE_W-1:0] m,
			input logic [wect_pkg::SYM_W-1:0] s);
		int gap;
		gap = tx_gap();
		repeat (gap) begin
			in_ch.valid = 1'b0;
			in_ch.mode = wect_pkg::MODE_W'($urandom);
			in_ch.symbol = wect_pkg::SYM_W'($urandom);
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.mode = m;
		in_ch.symbol = s;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_ch.valid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic write_switch_cost(input logic [wect_pkg::SWITCH_W-1:0] v);
		wait_idle();
		cfg_wr_en = 1'b1;
		cfg_wr_data = v;
		sb.set_switch_cost(v);
		@(negedge clk);
		cfg_wr_en = 1'b0;
		cfg_wr_data = wect_pkg::SWITCH_W'($urandom);
		@(negedge clk);
	endtask

	function automatic logic [wect_pkg::SYM_W-1:0] pick_symbol();
		if ($urandom_range(0, 99) < 55) return hot_syms[$urandom_range(0, 3)];
		return wect_pkg::SYM_W'($urandom_range(0, 255));
	endfunction

	task automatic send_random(input int n);
		int done;
		int r;
		int t;
		logic [wect_pkg::SYM_W-1:0] s;
		done = 0;
		foreach (hot_syms[i]) hot_syms[i] = wect_pkg::SYM_W'($urandom);
		while (done < n) begin
			r = $urandom_range(0, 99);
			s = pick_symbol();
			if (r < 55) begin
				send_item(wect_pkg::MODE_ADD, s);
				done++;
			end else if (r < 85) begin
				for (t = 0; t < 8 && sb.bin_count[s] == 0; t++) s = pick_symbol();
				send_item(wect_pkg::MODE_REMOVE, s);
				done++;
			end else if (r < 88) begin
				send_item(wect_pkg::MODE_CLEAR, wect_pkg::SYM_W'($urandom));
				done++;
			end else if (r < 93) begin
				send_item(MODE_UNUSED, s);
			end else begin
				send_item(wect_pkg::MODE_REMOVE, wect_pkg::SYM_W'($urandom));
				done++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_ch.valid = 1'b0;
		in_ch.mode = wect_pkg::MODE_ADD;
		in_ch.symbol = '0;
		tx_eager = 1'b0;
		rx_eager = 1'b0;
		hold_request = 1'b0;
		idle_cycles = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_item(wect_pkg::MODE_REMOVE, 8'h00);
		send_item(wect_pkg::MODE_ADD, 8'h00);
		send_item(wect_pkg::MODE_ADD, 8'hFF);
		send_item(wect_pkg::MODE_ADD, 8'hFF);
		send_item(wect_pkg::MODE_ADD, 8'hFF);
		send_item(wect_pkg::MODE_REMOVE, 8'hFF);
		send_item(wect_pkg::MODE_REMOVE, 8'h07);
		send_item(MODE_UNUSED, 8'hAA);
		send_item(wect_pkg::MODE_ADD, 8'h55);
		send_item(wect_pkg::MODE_ADD, 8'hAA);
		send_item(wect_pkg::MODE_REMOVE, 8'h00);
		send_item(wect_pkg::MODE_REMOVE, 8'h00);
		send_item(wect_pkg::MODE_CLEAR, 8'hFF);
		send_item(wect_pkg::MODE_REMOVE, 8'hFF);
		send_item(wect_pkg::MODE_ADD, 8'h80);
		send_item(wect_pkg::MODE_ADD, 8'h01);
		send_item(wect_pkg::MODE_ADD, 8'h01);
		send_item(MODE_UNUSED, 8'h55);
		send_item(wect_pkg::MODE_CLEAR, 8'h00);

		send_random(ITEMS_PHASE);

		write_switch_cost('0);
		send_random(ITEMS_PHASE);

		write_switch_cost({wect_pkg::SWITCH_W{1'b1}});
		send_random(ITEMS_PHASE / 2);
		hold_request = 1'b1;
		send_random(ITEMS_PHASE / 2);

		write_switch_cost(wect_pkg::SWITCH_W'($urandom));
		tx_eager = 1'b1;
		rx_eager = 1'b1;
		send_random(ITEMS_PHASE / 2);
		tx_eager = 1'b0;
		rx_eager = 1'b0;
		send_random(ITEMS_PHASE / 2);

		write_switch_cost(wect_pkg::SWITCH_RESET);
		send_random(ITEMS_PHASE);

		wait_idle();
		repeat (6) @(negedge clk);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
